### rtl/fte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fte_pkg
// Shared types, widths and codes of the screen fade envelope.
// ----------------------------------------------------------------------------
package fte_pkg;

  localparam int ELAPSED_WIDTH = 32;
  localparam int REG_W         = 24;
  localparam int FRAME_W       = 20;
  localparam int IDX_W         = 2;
  localparam int ALPHA_W       = 8;
  localparam int QUOT_W        = ALPHA_W;
  localparam int THR_W         = REG_W + 2;
  localparam int NUM_W         = REG_W + QUOT_W;
  localparam int CNT_W         = $clog2(QUOT_W);

  localparam logic [ALPHA_W-1:0] ALPHA_FULL = ALPHA_W'(255);

  localparam logic [REG_W-1:0] FADE_OUT_RST = REG_W'(500000);
  localparam logic [REG_W-1:0] HOLD_RST     = REG_W'(250000);
  localparam logic [REG_W-1:0] FADE_IN_RST  = REG_W'(500000);

  typedef enum logic [IDX_W-1:0] {
    REG_FADE_OUT = 2'd0,
    REG_HOLD     = 2'd1,
    REG_FADE_IN  = 2'd2
  } reg_idx_e;

  typedef enum logic {
    OP_ADVANCE = 1'b0,
    OP_RESTART = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PH_FADE_OUT = 2'd0,
    PH_HOLD     = 2'd1,
    PH_FADE_IN  = 2'd2,
    PH_DONE     = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_PHASE,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } st_e;

  typedef struct packed {
    logic [REG_W-1:0] fade_out;
    logic [REG_W-1:0] hold;
    logic [REG_W-1:0] fade_in;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [REG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic               color_white;
    logic [ALPHA_W-1:0] alpha;
    phase_e             phase;
    logic               fading_out;
    logic               fading_in;
    logic               faded_out_event;
    logic               faded_in_event;
  } res_t;

endpackage

### rtl/fte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fte_if
// Channel interfaces of the fade envelope: frame items, results, config.
// ----------------------------------------------------------------------------
interface fte_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [fte_pkg::FRAME_W-1:0] frame_ticks;
  logic                        fill_black;

  modport source (output valid, output operation, output frame_ticks,
                  output fill_black, input ready);
  modport sink   (input valid, input operation, input frame_ticks,
                  input fill_black, output ready);
endinterface

interface fte_out_if;
  logic                        valid;
  logic                        ready;
  logic                        color_white;
  logic [fte_pkg::ALPHA_W-1:0] alpha;
  logic [1:0]                  phase;
  logic                        fading_out;
  logic                        fading_in;
  logic                        faded_out_event;
  logic                        faded_in_event;

  modport source (output valid, output color_white, output alpha, output phase,
                  output fading_out, output fading_in, output faded_out_event,
                  output faded_in_event, input ready);
  modport sink   (input valid, input color_white, input alpha, input phase,
                  input fading_out, input fading_in, input faded_out_event,
                  input faded_in_event, output ready);
endinterface

interface fte_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [fte_pkg::IDX_W-1:0] index;
  logic [fte_pkg::REG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/fade_transition_envelope.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fade_transition_envelope
// Screen fade envelope: overlay opacity, phase and events per frame beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one beat per video frame; operation selects advance or restart,
//           frame_ticks is the frame time in microsecond ticks.
//   out_o : exactly one result beat per input beat, in order.
//   cfg_i : duration writes (index 0 fade out, 1 hold, 2 fade in); always
//           ready, write only while no frame is in flight.
// Flow: a restart beat goes straight to the emit state; an advance beat
//   adds its frame time, then picks the phase, and in a ramp also prepares
//   and runs the shared 8-step divider that forms the alpha value. One
//   frame is in work at a time, so no new beat is taken until the result
//   of the last one is parked in the output register.
// The input is ready again as soon as a result is parked in the output
// register, so the next beat may be taken while the receiver stalls; the
// sequencer waits only when a second result finds the register still full.
// Reset clears the accumulated time, the raised-event flags and the output
// valid, and loads the default durations.
// ----------------------------------------------------------------------------
module fade_transition_envelope (
  input  logic     clk_i,
  input  logic     rst_ni,
  fte_in_if.sink   in_i,
  fte_out_if.source out_o,
  fte_cfg_if.sink  cfg_i
);
  import fte_pkg::*;

  localparam int EW = ELAPSED_WIDTH;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  st_e                st_q, st_d;
  logic [EW-1:0]      elapsed_q, elapsed_d;
  logic               raised_out_q, raised_out_d;
  logic               raised_in_q, raised_in_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic               black_q, black_d;
  logic [THR_W-1:0]   b_q, b_d;
  logic [REG_W-1:0]   x_q, x_d;
  phase_e             phase_q, phase_d;
  logic [ALPHA_W-1:0] alpha_q, alpha_d;
  logic               ev_out_q, ev_out_d;
  logic               ev_in_q, ev_in_d;
  res_t               res_q, res_d;
  logic               out_valid_q, out_valid_d;

  logic [EW:0]        sum_w;
  logic [THR_W-1:0]   c_w;
  logic [EW-1:0]      diff_w;
  logic [NUM_W-1:0]   num_w;
  logic               in_fire;

  fte_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  fte_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready = (st_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  assign sum_w  = {1'b0, elapsed_q} + (EW + 1)'(frame_q);
  assign c_w    = b_q + THR_W'(cfg.fade_in);
  assign diff_w = elapsed_q - EW'(b_q);
  // x * 255 as a shift and subtract
  assign num_w  = (NUM_W'(x_q) << QUOT_W) - NUM_W'(x_q);

  always_comb begin
    st_d         = st_q;
    elapsed_d    = elapsed_q;
    raised_out_d = raised_out_q;
    raised_in_d  = raised_in_q;
    frame_d      = frame_q;
    black_d      = black_q;
    b_d          = b_q;
    x_d          = x_q;
    phase_d      = phase_q;
    alpha_d      = alpha_q;
    ev_out_d     = ev_out_q;
    ev_in_d      = ev_in_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    div_req      = '0;

    case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (op_e'(in_i.operation) == OP_RESTART) begin
            elapsed_d    = '0;
            raised_out_d = 1'b0;
            raised_in_d  = 1'b0;
            black_d      = 1'b1;
            phase_d      = PH_FADE_OUT;
            alpha_d      = '0;
            ev_out_d     = 1'b0;
            ev_in_d      = 1'b0;
            st_d         = ST_EMIT;
          end else begin
            frame_d = in_i.frame_ticks;
            black_d = in_i.fill_black;
            st_d    = ST_ACC;
          end
        end
      end

      ST_ACC: begin
        // saturate at the top of the accumulator
        elapsed_d = sum_w[EW] ? '1 : sum_w[EW-1:0];
        b_d       = THR_W'(cfg.fade_out) + THR_W'(cfg.hold);
        st_d      = ST_PHASE;
      end

      ST_PHASE: begin
        if (elapsed_q < EW'(cfg.fade_out)) begin
          phase_d = PH_FADE_OUT;
          x_d     = elapsed_q[REG_W-1:0];
          st_d    = ST_PREP;
        end else if (elapsed_q < EW'(b_q)) begin
          phase_d = PH_HOLD;
          alpha_d = ALPHA_FULL;
          st_d    = ST_EMIT;
        end else if (elapsed_q < EW'(c_w)) begin
          phase_d = PH_FADE_IN;
          x_d     = diff_w[REG_W-1:0];
          st_d    = ST_PREP;
        end else begin
          phase_d = PH_DONE;
          alpha_d = '0;
          st_d    = ST_EMIT;
        end
        // a frame may skip straight past hold, still raise both once
        ev_out_d = 1'b0;
        ev_in_d  = 1'b0;
        if (!(elapsed_q < EW'(cfg.fade_out)) && !raised_out_q) begin
          ev_out_d     = 1'b1;
          raised_out_d = 1'b1;
        end
        if (!(elapsed_q < EW'(c_w)) && !raised_in_q) begin
          ev_in_d     = 1'b1;
          raised_in_d = 1'b1;
        end
      end

      ST_PREP: begin
        div_req.start = 1'b1;
        if (phase_q == PH_FADE_IN) begin
          // round up: add divisor minus one
          div_req.dividend = num_w + NUM_W'(cfg.fade_in) - NUM_W'(1);
          div_req.divisor  = cfg.fade_in;
        end else begin
          div_req.dividend = num_w;
          div_req.divisor  = cfg.fade_out;
        end
        st_d = ST_DIV;
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          alpha_d = (phase_q == PH_FADE_IN) ? (ALPHA_FULL - div_rsp.quot) : div_rsp.quot;
          st_d    = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          res_d.color_white     = !black_q;
          res_d.alpha           = alpha_q;
          res_d.phase           = phase_q;
          res_d.fading_out      = (phase_q == PH_FADE_OUT);
          res_d.fading_in       = (phase_q == PH_FADE_IN);
          res_d.faded_out_event = ev_out_q;
          res_d.faded_in_event  = ev_in_q;
          out_valid_d           = 1'b1;
          st_d                  = ST_IDLE;
        end
      end

      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      elapsed_q    <= '0;
      raised_out_q <= 1'b0;
      raised_in_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      st_q         <= st_d;
      elapsed_q    <= elapsed_d;
      raised_out_q <= raised_out_d;
      raised_in_q  <= raised_in_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q  <= frame_d;
    black_q  <= black_d;
    b_q      <= b_d;
    x_q      <= x_d;
    phase_q  <= phase_d;
    alpha_q  <= alpha_d;
    ev_out_q <= ev_out_d;
    ev_in_q  <= ev_in_d;
    res_q    <= res_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.color_white     = res_q.color_white;
  assign out_o.alpha           = res_q.alpha;
  assign out_o.phase           = res_q.phase;
  assign out_o.fading_out      = res_q.fading_out;
  assign out_o.fading_in       = res_q.fading_in;
  assign out_o.faded_out_event = res_q.faded_out_event;
  assign out_o.faded_in_event  = res_q.faded_in_event;

`ifndef ASSERT_OFF
  a_done_event_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.faded_in_event |-> res_q.phase == PH_DONE)
    else $error("faded-in event outside the done phase");

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> st_q == ST_DIV)
    else $error("divider busy while the sequencer is not waiting on it");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.operation == OP_RESTART |=>
      elapsed_q == '0 && !raised_out_q && !raised_in_q)
    else $error("restart did not clear the envelope state");
`endif

endmodule

### rtl/fte_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fte_regs
// Duration registers: fade-out, hold and fade-in lengths in ticks.
// ----------------------------------------------------------------------------
module fte_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  fte_cfg_if.sink       cfg_i,
  output fte_pkg::cfg_t cfg_o
);
  import fte_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_FADE_OUT: cfg_d.fade_out = cfg_i.data;
        REG_HOLD:     cfg_d.hold     = cfg_i.data;
        REG_FADE_IN:  cfg_d.fade_in  = cfg_i.data;
        default:      cfg_d          = cfg_q;  // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fade_out <= FADE_OUT_RST;
      cfg_q.hold     <= HOLD_RST;
      cfg_q.fade_in  <= FADE_IN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/fte_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fte_div
// Restoring divider, one compare and subtract a cycle, 8-bit quotient.
// ----------------------------------------------------------------------------
module fte_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fte_pkg::div_req_t req_i,
  output fte_pkg::div_rsp_t rsp_o
);
  import fte_pkg::*;

  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  dvs_q, dvs_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              ge;

  assign ge = (rem_q >= dvs_q);

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      // quotient is known to fit, so start with the divisor at its top weight
      rem_d  = req_i.dividend;
      dvs_d  = NUM_W'(req_i.divisor) << (QUOT_W - 1);
      quot_d = '0;
      cnt_d  = CNT_W'(QUOT_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dvs_q;
      end
      quot_d = {quot_q[QUOT_W-2:0], ge};
      dvs_d  = dvs_q >> 1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule
